/* src/link_window_admission_unit_macros.svh */
// Assertion macros shared by the link window admission unit.
`ifndef LINK_WINDOW_ADMISSION_UNIT_MACROS_SVH
`define LINK_WINDOW_ADMISSION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LWA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

/* src/lwa_pkg.sv */
// Constants and codes for the link window admission unit.
package lwa_pkg;

    localparam int NUM_PAIRS_DEF = 64;
    localparam int PSN_BITS_DEF  = 24;

    localparam int MODE_W    = 2;
    localparam int QP_W      = 6;
    localparam int WIN_W     = 16;
    localparam int CNT_W     = 32;
    localparam int IN_PSN_W  = 24;
    localparam int OUT_PSN_W = 24;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [MODE_W-1:0] MODE_ADMIT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    // Register index as seen in the word address bits of paddr.
    localparam logic [APB_AW-3:0] REG_WINDOW = '0;

endpackage

/* src/link_window_admission_unit.sv */
// Credit-window admission for one link shared by many queue pairs.
//
// Requests enter on start with mode, qp_index, is_reliable, qp_dead, req_psn
// and comp_psn; busy is always low, so a request is taken in every cycle that
// start is high. Each request gives exactly one result, shown for a single
// cycle with o_valid high: o_admitted, o_kick, o_unacked_count, o_pair_charge.
// A request is registered into the update stage and its result into the
// result registers, and one request per cycle is sustained. The read step
// reads the per-pair charge table through its registered read port; the
// update step then updates the link count, the waiters flag and the table
// entry. Back-to-back requests to the same pair are forwarded around the
// table. The receiver cannot stall; results are not held.
// The window register is written through the APB port at byte address 0 and
// should only change while no request is in flight. A synchronous reset clears
// the link count, the waiters flag, the window and the valid bit of every
// table entry, so every pair charge reads as zero afterwards; no clearing
// pass is needed and requests are taken as soon as reset is released.
module link_window_admission_unit #(
    parameter int NUM_PAIRS = lwa_pkg::NUM_PAIRS_DEF,
    parameter int PSN_BITS  = lwa_pkg::PSN_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lwa_pkg::APB_AW-1:0]     paddr,
    input  logic [lwa_pkg::APB_DW-1:0]     pwdata,
    output logic [lwa_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic [lwa_pkg::MODE_W-1:0]     i_mode,
    input  logic [lwa_pkg::QP_W-1:0]       i_qp_index,
    input  logic                           i_is_reliable,
    input  logic                           i_qp_dead,
    input  logic [lwa_pkg::IN_PSN_W-1:0]   i_req_psn,
    input  logic [lwa_pkg::IN_PSN_W-1:0]   i_comp_psn,
    output logic                           o_valid,
    output logic                           o_admitted,
    output logic                           o_kick,
    output logic [lwa_pkg::CNT_W-1:0]      o_unacked_count,
    output logic [lwa_pkg::OUT_PSN_W-1:0]  o_pair_charge
);

`include "link_window_admission_unit_macros.svh"

    localparam int IDX_W = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam logic [PSN_BITS-1:0] CHARGE_MAX = '1;

    // Configuration.
    logic [lwa_pkg::WIN_W-1:0] r_window;
    logic                      cfg_wr;
    logic                      reg_sel;

    // Request acceptance and table read.
    logic             accept;
    logic             in_range;
    logic [IDX_W-1:0] rd_addr;

    // Charge table with one valid bit per entry.
    logic [PSN_BITS-1:0] r_mem [NUM_PAIRS];
    logic [NUM_PAIRS-1:0] r_ok_bits;
    logic [PSN_BITS-1:0] r_rd_data;
    logic                r_rd_ok;
    logic                r_byp;
    logic [PSN_BITS-1:0] r_byp_data;

    // Update stage registers.
    logic                         r_s1_vld;
    logic [lwa_pkg::MODE_W-1:0]   r_s1_mode;
    logic [IDX_W-1:0]             r_s1_addr;
    logic                         r_s1_inrange;
    logic                         r_s1_rel;
    logic                         r_s1_dead;
    logic [lwa_pkg::IN_PSN_W-1:0] r_s1_req;
    logic [lwa_pkg::IN_PSN_W-1:0] r_s1_comp;

    // Link state.
    logic [lwa_pkg::CNT_W-1:0] r_unacked;
    logic                      r_waiters;

    // Update stage logic.
    logic [PSN_BITS-1:0]       cur_charge;
    logic [lwa_pkg::WIN_W-1:0] eff_win;
    logic [PSN_BITS-1:0]       target;
    logic [lwa_pkg::CNT_W-1:0] release_amt;
    logic [lwa_pkg::CNT_W-1:0] topup_amt;
    logic [lwa_pkg::CNT_W-1:0] cnt_rel;
    logic [lwa_pkg::CNT_W:0]   topup_sum;
    logic [lwa_pkg::CNT_W-1:0] cnt_top;
    logic [lwa_pkg::CNT_W-1:0] n_unacked;
    logic                      n_waiters;
    logic [PSN_BITS-1:0]       n_charge;
    logic                      wr_en;
    logic                      n_admitted;
    logic                      n_kick;

    // Result registers.
    logic                          r_done;
    logic                          r_admitted;
    logic                          r_kick;
    logic [lwa_pkg::CNT_W-1:0]     r_count_out;
    logic [lwa_pkg::OUT_PSN_W-1:0] r_charge_out;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_sel = (paddr[lwa_pkg::APB_AW-1:2] == lwa_pkg::REG_WINDOW);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_sel ? lwa_pkg::APB_DW'(r_window) : '0;

    assign accept   = start && !busy;
    assign in_range = (32'(i_qp_index) < 32'(NUM_PAIRS));
    assign rd_addr  = IDX_W'(i_qp_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
        end else if (cfg_wr && reg_sel) begin
            r_window <= pwdata[lwa_pkg::WIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= n_charge;
        end
    end

    // Registered table read; a write to the same entry in this cycle wins.
    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_ok    <= r_ok_bits[rd_addr];
            r_byp      <= wr_en && (r_s1_addr == rd_addr);
            r_byp_data <= n_charge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode    <= i_mode;
            r_s1_addr    <= rd_addr;
            r_s1_inrange <= in_range;
            r_s1_rel     <= i_is_reliable;
            r_s1_dead    <= i_qp_dead;
            r_s1_req     <= i_req_psn;
            r_s1_comp    <= i_comp_psn;
        end
    end

    assign cur_charge = r_byp ? r_byp_data : (r_rd_ok ? r_rd_data : '0);
    assign eff_win    = (r_window == '0) ? lwa_pkg::WIN_W'(1) : r_window;
    assign target     = r_s1_dead ? '0
                                  : (PSN_BITS'(r_s1_req) - PSN_BITS'(r_s1_comp));

    assign release_amt = lwa_pkg::CNT_W'(cur_charge - target);
    assign topup_amt   = lwa_pkg::CNT_W'(target - cur_charge);
    assign cnt_rel     = (release_amt < r_unacked) ? (r_unacked - release_amt) : '0;
    assign topup_sum   = {1'b0, r_unacked} + {1'b0, topup_amt};
    assign cnt_top     = topup_sum[lwa_pkg::CNT_W] ? '1 : topup_sum[lwa_pkg::CNT_W-1:0];

    always_comb begin
        n_unacked  = r_unacked;
        n_waiters  = r_waiters;
        n_charge   = cur_charge;
        wr_en      = 1'b0;
        n_admitted = 1'b0;
        n_kick     = 1'b0;
        if (r_s1_vld) begin
            case (r_s1_mode)
                lwa_pkg::MODE_RESET: begin
                    n_unacked = '0;
                    n_waiters = 1'b0;
                end
                lwa_pkg::MODE_ADMIT: begin
                    if (r_s1_inrange) begin
                        if (r_unacked >= lwa_pkg::CNT_W'(eff_win)) begin
                            n_waiters = 1'b1;
                        end else begin
                            n_unacked  = r_unacked + 1'b1;
                            n_admitted = 1'b1;
                            wr_en      = 1'b1;
                            if (cur_charge != CHARGE_MAX) begin
                                n_charge = cur_charge + 1'b1;
                            end
                        end
                    end
                end
                lwa_pkg::MODE_SYNC: begin
                    if (r_s1_inrange && r_s1_rel) begin
                        if (cur_charge > target) begin
                            n_unacked = cnt_rel;
                            n_charge  = target;
                            wr_en     = 1'b1;
                            // The release reopened the window for parked pairs.
                            if (r_waiters && (cnt_rel < lwa_pkg::CNT_W'(eff_win))) begin
                                n_waiters = 1'b0;
                                n_kick    = 1'b1;
                            end
                        end else if (cur_charge < target) begin
                            n_unacked = cnt_top;
                            n_charge  = target;
                            wr_en     = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_done    <= 1'b0;
            r_unacked <= '0;
            r_waiters <= 1'b0;
            r_ok_bits <= '0;
        end else begin
            r_s1_vld  <= accept;
            r_done    <= r_s1_vld;
            r_unacked <= n_unacked;
            r_waiters <= n_waiters;
            if (wr_en) begin
                r_ok_bits[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_admitted   <= n_admitted;
            r_kick       <= n_kick;
            r_count_out  <= n_unacked;
            r_charge_out <= r_s1_inrange ? lwa_pkg::OUT_PSN_W'(n_charge) : '0;
        end
    end

    assign o_valid         = r_done;
    assign o_admitted      = r_admitted;
    assign o_kick          = r_kick;
    assign o_unacked_count = r_count_out;
    assign o_pair_charge   = r_charge_out;

    `LWA_ASSERT_SAME(a_result_latency, accept, ##2 o_valid, "result missing two cycles after request")
    `LWA_ASSERT_SAME(a_admit_counts, o_valid && o_admitted, (o_unacked_count != '0), "admit left count at zero")
    `LWA_ASSERT_SAME(a_kick_clears, o_valid && o_kick, !r_waiters, "kick with waiters still set")
    `LWA_ASSERT_SAME(a_grant_xor_kick, o_valid, !(o_admitted && o_kick), "admit and kick in one result")
    `LWA_ASSERT_NEXT(a_reset_clears, r_s1_vld && (r_s1_mode == lwa_pkg::MODE_RESET), (r_unacked == '0) && !r_waiters, "session reset did not clear link state")

endmodule
